>>> sv/chcp_pkg.sv
package chcp_pkg;

  localparam int COORD_W   = 16;
  localparam int TAN_W     = 17;
  localparam int PT_W      = 18;
  localparam int SEG_W     = 6;
  localparam int COEF_W    = 20;
  localparam int T_FRAC    = 16;
  localparam int T_W       = T_FRAC + 1;
  localparam int DIV_CNT_W = $clog2(T_FRAC + 1);
  localparam int LIMB_W    = 18;
  localparam int ACC_W     = 3 * LIMB_W;
  localparam int PROD_W    = LIMB_W + T_W + 2;
  localparam int WIDE_W    = 72;
  localparam int CFG_DW    = 32;
  localparam int PADDR_W   = 3;
  localparam int QUEUE_AW  = 1;
  localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

  localparam logic [SEG_W-1:0] SEG_RESET    = SEG_W'(5);
  localparam logic [SEG_W-1:0] MAX_SEGMENTS = SEG_W'(63);
  localparam logic [T_W-1:0]   T_ONE        = T_W'(1) << T_FRAC;
  localparam logic             REG_SEGMENTS = 1'b0;

  typedef logic signed [COEF_W-1:0] coef_t;

  typedef struct packed {
    coef_t a;
    coef_t b;
    coef_t c;
    coef_t d;
  } poly_t;

  typedef struct packed {
    poly_t             x;
    poly_t             y;
    logic [SEG_W-1:0]  n;
    logic [T_W-1:0]    q_step;
    logic [SEG_W-1:0]  r_step;
  } job_t;

  function automatic poly_t make_poly(input logic [COORD_W-1:0] p0,
                                      input logic signed [TAN_W-1:0] t0,
                                      input logic [COORD_W-1:0] p1,
                                      input logic signed [TAN_W-1:0] t1);
    logic signed [COEF_W:0] sp0;
    logic signed [COEF_W:0] sp1;
    logic signed [COEF_W:0] st0;
    logic signed [COEF_W:0] st1;
    logic signed [COEF_W:0] dp;
    logic signed [COEF_W:0] ca;
    logic signed [COEF_W:0] cb;
    poly_t r;
    sp0 = $signed({{(COEF_W + 1 - COORD_W){1'b0}}, p0});
    sp1 = $signed({{(COEF_W + 1 - COORD_W){1'b0}}, p1});
    st0 = (COEF_W + 1)'(t0);
    st1 = (COEF_W + 1)'(t1);
    dp  = sp1 - sp0;
    ca  = st0 + st1 - (dp <<< 1);
    cb  = dp + (dp <<< 1) - (st0 <<< 1) - st1;
    r.a = COEF_W'(ca);
    r.b = COEF_W'(cb);
    r.c = COEF_W'(st0);
    r.d = COEF_W'(sp0);
    return r;
  endfunction

endpackage

>>> sv/chcp_front.sv
module chcp_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push,
  output logic                                full,
  input  logic [chcp_pkg::COORD_W-1:0]        in_start_x,
  input  logic [chcp_pkg::COORD_W-1:0]        in_start_y,
  input  logic signed [chcp_pkg::TAN_W-1:0]   in_start_tangent_x,
  input  logic signed [chcp_pkg::TAN_W-1:0]   in_start_tangent_y,
  input  logic [chcp_pkg::COORD_W-1:0]        in_end_x,
  input  logic [chcp_pkg::COORD_W-1:0]        in_end_y,
  input  logic signed [chcp_pkg::TAN_W-1:0]   in_end_tangent_x,
  input  logic signed [chcp_pkg::TAN_W-1:0]   in_end_tangent_y,
  input  logic [chcp_pkg::SEG_W-1:0]          segments,
  output logic                                q_wr,
  output chcp_pkg::job_t                      q_wdata,
  input  logic                                q_full
);
  import chcp_pkg::*;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_DIV  = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  logic [1:0]           state_r, state_nxt;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [SEG_W-1:0]     rem_r;
  logic [T_W-1:0]       quo_r;
  poly_t                x_r, y_r;
  logic [SEG_W-1:0]     n_r;
  logic [SEG_W-1:0]     n_eff;
  logic [SEG_W:0]       shifted;
  logic [SEG_W:0]       diff;
  logic                 ge;
  logic                 accept;

  assign accept = push && (state_r == F_IDLE);
  assign full   = (state_r != F_IDLE);

  always_comb begin
    if (segments == '0) begin
      n_eff = SEG_W'(1);
    end else if (segments > MAX_SEGMENTS) begin
      n_eff = MAX_SEGMENTS;
    end else begin
      n_eff = segments;
    end
  end

  assign shifted = {rem_r, (cnt_r == DIV_CNT_W'(T_FRAC))};
  assign ge      = (shifted >= {1'b0, n_r});
  assign diff    = shifted - {1'b0, n_r};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: if (accept) state_nxt = F_DIV;
      F_DIV:  if (cnt_r == '0) state_nxt = F_PUSH;
      F_PUSH: if (!q_full) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_r   <= make_poly(in_start_x, in_start_tangent_x, in_end_x, in_end_tangent_x);
      y_r   <= make_poly(in_start_y, in_start_tangent_y, in_end_y, in_end_tangent_y);
      n_r   <= n_eff;
      cnt_r <= DIV_CNT_W'(T_FRAC);
      rem_r <= '0;
      quo_r <= '0;
    end else if (state_r == F_DIV) begin
      rem_r <= ge ? diff[SEG_W-1:0] : shifted[SEG_W-1:0];
      quo_r <= {quo_r[T_W-2:0], ge};
      cnt_r <= cnt_r - DIV_CNT_W'(1);
    end
  end

  assign q_wr           = (state_r == F_PUSH) && !q_full;
  assign q_wdata.x      = x_r;
  assign q_wdata.y      = y_r;
  assign q_wdata.n      = n_r;
  assign q_wdata.q_step = quo_r;
  assign q_wdata.r_step = rem_r;

endmodule

>>> sv/chcp_queue.sv
module chcp_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr,
  input  chcp_pkg::job_t wdata,
  output logic           full,
  input  logic           rd,
  output chcp_pkg::job_t rdata,
  output logic           empty
);
  import chcp_pkg::*;

  job_t                mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QUEUE_AW:0]   count_r;

  assign full  = (count_r == (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr) wr_ptr_r <= wr_ptr_r + QUEUE_AW'(1);
      if (rd) rd_ptr_r <= rd_ptr_r + QUEUE_AW'(1);
      if (wr && !rd) begin
        count_r <= count_r + (QUEUE_AW + 1)'(1);
      end else if (rd && !wr) begin
        count_r <= count_r - (QUEUE_AW + 1)'(1);
      end
    end
  end

endmodule

>>> sv/chcp_lane.sv
module chcp_lane (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  chcp_pkg::poly_t                   poly,
  input  logic [chcp_pkg::T_W-1:0]          t,
  output logic                              done,
  output logic signed [chcp_pkg::PT_W-1:0]  point
);
  import chcp_pkg::*;

  localparam logic [1:0] LIMB_HI  = 2'd0;
  localparam logic [1:0] LIMB_MID = 2'd1;
  localparam logic [1:0] LIMB_LO  = 2'd2;
  localparam logic [1:0] STEP_B   = 2'd0;
  localparam logic [1:0] STEP_C   = 2'd1;
  localparam logic [1:0] STEP_D   = 2'd2;

  localparam logic signed [WIDE_W-1:0] RND_HALF    = WIDE_W'(1) <<< (3 * T_FRAC - 1);
  localparam logic signed [WIDE_W-1:0] RND_HALF_M1 = RND_HALF - WIDE_W'(1);

  logic                       busy_r, fin_r, done_r;
  logic [1:0]                 limb_r, step_r;
  logic signed [ACC_W-1:0]    acc_r;
  logic signed [WIDE_W-1:0]   p_r, p_nxt;
  logic signed [PT_W-1:0]     point_r;
  logic signed [LIMB_W:0]     opnd;
  logic signed [PROD_W-1:0]   prod;
  logic signed [WIDE_W-1:0]   base, addend, rnd;

  always_comb begin
    unique case (limb_r)
      LIMB_HI:  opnd = $signed({acc_r[ACC_W-1], acc_r[ACC_W-1 -: LIMB_W]});
      LIMB_MID: opnd = $signed({1'b0, acc_r[2*LIMB_W-1 -: LIMB_W]});
      LIMB_LO:  opnd = $signed({1'b0, acc_r[LIMB_W-1:0]});
      default:  opnd = '0;
    endcase
  end

  assign prod = opnd * $signed({1'b0, t});
  assign base = (limb_r == LIMB_HI) ? '0 : (p_r <<< LIMB_W);

  always_comb begin
    addend = '0;
    if (limb_r == LIMB_LO) begin
      unique case (step_r)
        STEP_B:  addend = WIDE_W'(poly.b) <<< T_FRAC;
        STEP_C:  addend = WIDE_W'(poly.c) <<< (2 * T_FRAC);
        STEP_D:  addend = WIDE_W'(poly.d) <<< (3 * T_FRAC);
        default: addend = '0;
      endcase
    end
  end

  assign p_nxt = base + WIDE_W'(prod) + addend;
  assign rnd   = p_r + (p_r[WIDE_W-1] ? RND_HALF_M1 : RND_HALF);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      limb_r <= LIMB_HI;
      step_r <= STEP_B;
    end else begin
      fin_r  <= 1'b0;
      done_r <= fin_r;
      if (start) begin
        busy_r <= 1'b1;
        limb_r <= LIMB_HI;
        step_r <= STEP_B;
      end else if (busy_r) begin
        if (limb_r == LIMB_LO) begin
          limb_r <= LIMB_HI;
          if (step_r == STEP_D) begin
            busy_r <= 1'b0;
            fin_r  <= 1'b1;
          end else begin
            step_r <= step_r + 2'd1;
          end
        end else begin
          limb_r <= limb_r + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= ACC_W'(poly.a);
    end else if (busy_r) begin
      p_r <= p_nxt;
      if (limb_r == LIMB_LO) begin
        acc_r <= p_nxt[ACC_W-1:0];
      end
    end
    if (fin_r) begin
      point_r <= rnd[3*T_FRAC +: PT_W];
    end
  end

  assign done  = done_r;
  assign point = point_r;

endmodule

>>> sv/chcp_back.sv
module chcp_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_empty,
  input  chcp_pkg::job_t                    q_head,
  output logic                              q_pop,
  output logic                              empty,
  input  logic                              pop,
  output logic signed [chcp_pkg::PT_W-1:0]  out_point_x,
  output logic signed [chcp_pkg::PT_W-1:0]  out_point_y,
  output logic                              out_last_point
);
  import chcp_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CALC = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0]            state_r;
  logic [SEG_W-1:0]      k_r;
  logic [T_W-1:0]        t_r;
  logic [SEG_W-1:0]      rem_r;
  logic                  start_r;
  logic                  out_valid_r;
  logic signed [PT_W-1:0] out_x_r, out_y_r;
  logic                  out_last_r;
  logic                  x_done, y_done;
  logic signed [PT_W-1:0] x_pt, y_pt;
  logic [SEG_W:0]        rem_sum;
  logic [SEG_W:0]        rem_wrap;
  logic                  wrap;
  logic [T_W-1:0]        t_next;
  logic                  out_free, out_wr, is_last;

  chcp_lane u_lane_x (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_r),
    .poly  (q_head.x),
    .t     (t_r),
    .done  (x_done),
    .point (x_pt)
  );

  chcp_lane u_lane_y (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_r),
    .poly  (q_head.y),
    .t     (t_r),
    .done  (y_done),
    .point (y_pt)
  );

  assign rem_sum  = {1'b0, rem_r} + {1'b0, q_head.r_step};
  assign wrap     = (rem_sum >= {1'b0, q_head.n});
  assign rem_wrap = rem_sum - {1'b0, q_head.n};
  assign t_next   = T_W'(t_r + q_head.q_step + T_W'(wrap));

  assign out_free = !out_valid_r || pop;
  assign out_wr   = (state_r == S_OUT) && out_free;
  assign is_last  = (k_r == q_head.n);
  assign q_pop    = out_wr && is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      start_r <= 1'b0;
      if (pop && out_valid_r) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            start_r <= 1'b1;
            state_r <= S_CALC;
          end
        end
        S_CALC: begin
          if (x_done) state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            if (is_last) begin
              state_r <= S_IDLE;
            end else begin
              start_r <= 1'b1;
              state_r <= S_CALC;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE) begin
      k_r   <= '0;
      t_r   <= '0;
      rem_r <= q_head.n >> 1;
    end else if (out_wr && !is_last) begin
      k_r   <= k_r + SEG_W'(1);
      t_r   <= t_next;
      rem_r <= wrap ? rem_wrap[SEG_W-1:0] : rem_sum[SEG_W-1:0];
    end
    if (out_wr) begin
      out_x_r    <= x_pt;
      out_y_r    <= y_pt;
      out_last_r <= is_last;
    end
  end

  assign empty          = !out_valid_r;
  assign out_point_x    = out_x_r;
  assign out_point_y    = out_y_r;
  assign out_last_point = out_last_r;

  a_lanes_in_step: assert property (@(posedge clk) disable iff (!rst_n)
    x_done == y_done) else $error("axis lanes out of step");

  a_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
    x_done |-> state_r == S_CALC) else $error("lane finished outside calc");

  a_last_t_one: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> t_r == T_ONE) else $error("final point not at t equal one");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> rem_r < q_head.n) else $error("step remainder out of range");

  a_job_held: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !q_empty) else $error("curve request lost while busy");

endmodule

>>> sv/cubic_hermite_curve_points.sv
// Channel   Handshake          Payload
// input     push / full        in_start_*, in_end_*, in_*_tangent_* (one curve request)
// result    pop / empty        out_point_x, out_point_y, out_last_point
// config    psel/penable/...   segments at byte address 0 (6 bits, reset 5)
//
// Each point passes through the Horner lanes in order: start, 9 limb multiplies,
// round, done and handoff; a curve yields N+1 points.
// The front end handles each request in order: accept, 17 divide steps, queue
// write, overlapped with the previous curve through a two-entry queue.
// Reset is synchronous; segments returns to 5 and the queue and the result output empty.
// Full is high while the front end divides or writes to the queue, also while it waits
// on a full queue; a held result stalls the lanes.
module cubic_hermite_curve_points (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push,
  output logic                                full,
  input  logic [chcp_pkg::COORD_W-1:0]        in_start_x,
  input  logic [chcp_pkg::COORD_W-1:0]        in_start_y,
  input  logic signed [chcp_pkg::TAN_W-1:0]   in_start_tangent_x,
  input  logic signed [chcp_pkg::TAN_W-1:0]   in_start_tangent_y,
  input  logic [chcp_pkg::COORD_W-1:0]        in_end_x,
  input  logic [chcp_pkg::COORD_W-1:0]        in_end_y,
  input  logic signed [chcp_pkg::TAN_W-1:0]   in_end_tangent_x,
  input  logic signed [chcp_pkg::TAN_W-1:0]   in_end_tangent_y,
  output logic                                empty,
  input  logic                                pop,
  output logic signed [chcp_pkg::PT_W-1:0]    out_point_x,
  output logic signed [chcp_pkg::PT_W-1:0]    out_point_y,
  output logic                                out_last_point,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [chcp_pkg::PADDR_W-1:0]        paddr,
  input  logic [chcp_pkg::CFG_DW-1:0]         pwdata,
  output logic [chcp_pkg::CFG_DW-1:0]         prdata,
  output logic                                pready
);
  import chcp_pkg::*;

  logic [SEG_W-1:0] segments_r;
  logic             cfg_wr;
  logic             q_wr, q_full, q_rd, q_empty;
  job_t             q_wdata, q_rdata;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_SEGMENTS);
  assign prdata = (paddr[2] == REG_SEGMENTS) ? CFG_DW'(segments_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      segments_r <= SEG_RESET;
    end else if (cfg_wr) begin
      segments_r <= pwdata[SEG_W-1:0];
    end
  end

  chcp_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .push               (push),
    .full               (full),
    .in_start_x         (in_start_x),
    .in_start_y         (in_start_y),
    .in_start_tangent_x (in_start_tangent_x),
    .in_start_tangent_y (in_start_tangent_y),
    .in_end_x           (in_end_x),
    .in_end_y           (in_end_y),
    .in_end_tangent_x   (in_end_tangent_x),
    .in_end_tangent_y   (in_end_tangent_y),
    .segments           (segments_r),
    .q_wr               (q_wr),
    .q_wdata            (q_wdata),
    .q_full             (q_full)
  );

  chcp_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (q_wr),
    .wdata (q_wdata),
    .full  (q_full),
    .rd    (q_rd),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  chcp_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_head         (q_rdata),
    .q_pop          (q_rd),
    .empty          (empty),
    .pop            (pop),
    .out_point_x    (out_point_x),
    .out_point_y    (out_point_y),
    .out_last_point (out_last_point)
  );

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import chcp_pkg::*;

  localparam logic [PADDR_W-1:0] SEGMENTS_ADDR = PADDR_W'(4 * REG_SEGMENTS);
  localparam logic [PADDR_W-1:0] UNUSED_ADDR   = PADDR_W'(4);
  localparam int NUM_DIRECTED  = 12;
  localparam int NUM_BLOCKS    = 12;
  localparam int BLOCK_CURVES  = 35;
  localparam int SETTLE_CYCLES = 900;

  typedef struct packed {
    logic [COORD_W-1:0]      start_x;
    logic [COORD_W-1:0]      start_y;
    logic signed [TAN_W-1:0] start_tangent_x;
    logic signed [TAN_W-1:0] start_tangent_y;
    logic [COORD_W-1:0]      end_x;
    logic [COORD_W-1:0]      end_y;
    logic signed [TAN_W-1:0] end_tangent_x;
    logic signed [TAN_W-1:0] end_tangent_y;
  } curve_t;

  typedef struct packed {
    logic signed [PT_W-1:0] x;
    logic signed [PT_W-1:0] y;
    logic                   last;
  } point_t;

  typedef struct packed {
    logic                   wr;
    logic [PADDR_W-1:0]     addr;
    logic [CFG_DW-1:0]      data;
    curve_t                 curve;
    logic                   flat;
    logic signed [PT_W-1:0] fx;
    logic signed [PT_W-1:0] fy;
  } plan_row_t;

  localparam plan_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    '{1'b0, SEGMENTS_ADDR, 0, '{0, 0, 0, 0, 0, 0, 0, 0}, 1'b1, 0, 0},
    '{1'b0, SEGMENTS_ADDR, 0, '{65535, 65535, 0, 0, 65535, 65535, 0, 0},
      1'b1, 65535, 65535},
    '{1'b1, SEGMENTS_ADDR, 1, '{0, 65535, 0, 0, 65535, 0, 0, 0}, 1'b0, 0, 0},
    '{1'b1, SEGMENTS_ADDR, 0, '{100, 200, 65535, -65536, 300, 400, -65536, 65535},
      1'b0, 0, 0},
    '{1'b1, SEGMENTS_ADDR, 63, '{0, 0, 65535, 65535, 65535, 65535, 65535, 65535},
      1'b0, 0, 0},
    '{1'b1, UNUSED_ADDR, 1, '{65535, 0, -65536, -65536, 0, 65535, -65536, -65536},
      1'b0, 0, 0},
    '{1'b0, SEGMENTS_ADDR, 0,
      '{32768, 32767, -65535, -65535, 32767, 32768, -65535, -65535}, 1'b0, 0, 0},
    '{1'b1, SEGMENTS_ADDR, 32'hFFFF_FFC2, '{12345, 54321, 0, 0, 12345, 54321, 0, 0},
      1'b1, 12345, 54321},
    '{1'b1, SEGMENTS_ADDR, 3, '{1, 1, -1, 1, 65534, 2, 1, -1}, 1'b0, 0, 0},
    '{1'b1, SEGMENTS_ADDR, 62, '{65535, 0, 65535, -65535, 0, 65535, -65535, 65535},
      1'b0, 0, 0},
    '{1'b0, SEGMENTS_ADDR, 0, '{65535, 65535, -1, -1, 65535, 65535, -1, -1},
      1'b0, 0, 0},
    '{1'b1, SEGMENTS_ADDR, 5, '{65535, 65535, 65535, -65536, 0, 0, -65536, 65535},
      1'b0, 0, 0}
  };

  logic                      clk;
  logic                      rst_n = 1'b0;
  logic                      push = 1'b0;
  logic                      full;
  logic [COORD_W-1:0]        in_start_x = '0;
  logic [COORD_W-1:0]        in_start_y = '0;
  logic signed [TAN_W-1:0]   in_start_tangent_x = '0;
  logic signed [TAN_W-1:0]   in_start_tangent_y = '0;
  logic [COORD_W-1:0]        in_end_x = '0;
  logic [COORD_W-1:0]        in_end_y = '0;
  logic signed [TAN_W-1:0]   in_end_tangent_x = '0;
  logic signed [TAN_W-1:0]   in_end_tangent_y = '0;
  logic                      empty;
  logic                      pop = 1'b0;
  logic signed [PT_W-1:0]    out_point_x;
  logic signed [PT_W-1:0]    out_point_y;
  logic                      out_last_point;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [PADDR_W-1:0]        paddr = '0;
  logic [CFG_DW-1:0]         pwdata = '0;
  logic [CFG_DW-1:0]         prdata;
  logic                      pready;

  point_t            expected_points[$];
  logic [SEG_W-1:0]  segments_cfg = SEG_RESET;
  int unsigned       send_idle_pct = 25;
  int unsigned       recv_idle_pct = 75;
  int                failures = 0;

  cubic_hermite_curve_points i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .push               (push),
    .full               (full),
    .in_start_x         (in_start_x),
    .in_start_y         (in_start_y),
    .in_start_tangent_x (in_start_tangent_x),
    .in_start_tangent_y (in_start_tangent_y),
    .in_end_x           (in_end_x),
    .in_end_y           (in_end_y),
    .in_end_tangent_x   (in_end_tangent_x),
    .in_end_tangent_y   (in_end_tangent_y),
    .empty              (empty),
    .pop                (pop),
    .out_point_x        (out_point_x),
    .out_point_y        (out_point_y),
    .out_last_point     (out_last_point),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic [PT_W-1:0] hermite_axis(input logic [COORD_W-1:0] p0,
                                                   input logic signed [TAN_W-1:0] t0,
                                                   input logic [COORD_W-1:0] p1,
                                                   input logic signed [TAN_W-1:0] t1,
                                                   input logic [T_W-1:0] t);
    longint sp0;
    longint sp1;
    longint st0;
    longint st1;
    logic signed [127:0] ka;
    logic signed [127:0] kb;
    logic signed [127:0] kc;
    logic signed [127:0] kd;
    logic signed [127:0] tw;
    logic signed [127:0] acc;
    logic signed [127:0] mag;
    logic neg;
    sp0 = longint'(p0);
    sp1 = longint'(p1);
    st0 = longint'(t0);
    st1 = longint'(t1);
    ka = 2 * sp0 + st0 - 2 * sp1 + st1;
    kb = 3 * sp1 - 3 * sp0 - 2 * st0 - st1;
    kc = st0;
    kd = sp0;
    tw = {{(128 - T_W){1'b0}}, t};
    acc = ka * tw + (kb <<< T_FRAC);
    acc = acc * tw + (kc <<< (2 * T_FRAC));
    acc = acc * tw + (kd <<< (3 * T_FRAC));
    neg = acc[127];
    mag = neg ? -acc : acc;
    mag = (mag + (128'sd1 <<< (3 * T_FRAC - 1))) >>> (3 * T_FRAC);
    acc = neg ? -mag : mag;
    return acc[PT_W-1:0];
  endfunction

  task automatic predict_curve_points(input curve_t c, input logic flat,
                                      input logic signed [PT_W-1:0] fx,
                                      input logic signed [PT_W-1:0] fy);
    int n;
    logic [T_W-1:0] t;
    point_t p;
    n = (segments_cfg == '0) ? 1 : int'(segments_cfg);
    if (n > int'(MAX_SEGMENTS)) n = int'(MAX_SEGMENTS);
    for (int k = 0; k <= n; k++) begin
      t = T_W'(((k << T_FRAC) + n / 2) / n);
      if (flat) begin
        p.x = fx;
        p.y = fy;
      end else begin
        p.x = hermite_axis(c.start_x, c.start_tangent_x, c.end_x, c.end_tangent_x, t);
        p.y = hermite_axis(c.start_y, c.start_tangent_y, c.end_y, c.end_tangent_y, t);
      end
      p.last = (k == n);
      expected_points.push_back(p);
    end
  endtask

  function automatic logic [COORD_W-1:0] draw_coord();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return COORD_W'($urandom_range(65535));
    endcase
  endfunction

  function automatic logic signed [TAN_W-1:0] draw_tangent();
    case ($urandom_range(7))
      0: return TAN_W'(-65536);
      1: return TAN_W'(65535);
      2: return '0;
      default: return TAN_W'($urandom());
    endcase
  endfunction

  function automatic curve_t random_curve();
    curve_t c;
    c.start_x         = draw_coord();
    c.start_y         = draw_coord();
    c.start_tangent_x = draw_tangent();
    c.start_tangent_y = draw_tangent();
    c.end_x           = draw_coord();
    c.end_y           = draw_coord();
    c.end_tangent_x   = draw_tangent();
    c.end_tangent_y   = draw_tangent();
    return c;
  endfunction

  // hold the request until full drops, then record its points
  task automatic send_curve(input curve_t c, input logic flat,
                            input logic signed [PT_W-1:0] fx,
                            input logic signed [PT_W-1:0] fy);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push               <= 1'b1;
    in_start_x         <= c.start_x;
    in_start_y         <= c.start_y;
    in_start_tangent_x <= c.start_tangent_x;
    in_start_tangent_y <= c.start_tangent_y;
    in_end_x           <= c.end_x;
    in_end_y           <= c.end_y;
    in_end_tangent_x   <= c.end_tangent_x;
    in_end_tangent_y   <= c.end_tangent_y;
    do @(posedge clk); while (full);
    predict_curve_points(c, flat, fx, fy);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
  endtask

  // write, then read segments back in the following transfer
  task automatic write_register(input logic [PADDR_W-1:0] addr, input logic [CFG_DW-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == SEGMENTS_ADDR) segments_cfg = data[SEG_W-1:0];
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= SEGMENTS_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[SEG_W-1:0] !== segments_cfg) begin
      $error("segments: expected %0d, got %0d", segments_cfg, prdata[SEG_W-1:0]);
      failures++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  always @(posedge clk) begin : point_check
    point_t want;
    if (rst_n && pop && !empty) begin
      if (expected_points.size() == 0) begin
        $error("point_x: expected none, got %0d", out_point_x);
        failures++;
      end else begin
        want = expected_points.pop_front();
        if (out_point_x !== want.x) begin
          $error("point_x: expected %0d, got %0d", want.x, out_point_x);
          failures++;
        end
        if (out_point_y !== want.y) begin
          $error("point_y: expected %0d, got %0d", want.y, out_point_y);
          failures++;
        end
        if (out_last_point !== want.last) begin
          $error("last_point: expected %0d, got %0d", want.last, out_last_point);
          failures++;
        end
      end
    end
    pop <= ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin : stimulus
    logic [SEG_W-1:0] seg;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    foreach (DIRECTED_ROWS[i]) begin
      if (DIRECTED_ROWS[i].wr) begin
        drain();
        write_register(DIRECTED_ROWS[i].addr, DIRECTED_ROWS[i].data);
      end
      send_curve(DIRECTED_ROWS[i].curve, DIRECTED_ROWS[i].flat,
                 DIRECTED_ROWS[i].fx, DIRECTED_ROWS[i].fy);
    end
    for (int b = 0; b < NUM_BLOCKS; b++) begin
      drain();
      if (b < 4) begin
        send_idle_pct = 25;
        recv_idle_pct = 75;
      end else if (b < 8) begin
        send_idle_pct = 75;
        recv_idle_pct = 25;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if ($urandom_range(2) == 0) write_register(UNUSED_ADDR, $urandom());
      if (b == 5) seg = MAX_SEGMENTS;
      else if (b == 9) seg = '0;
      else seg = SEG_W'($urandom_range(1, 12));
      write_register(SEGMENTS_ADDR, ($urandom() & 32'hFFFF_FFC0) | CFG_DW'(seg));
      repeat (BLOCK_CURVES) send_curve(random_curve(), 1'b0, '0, '0);
    end
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (failures == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

>>> files.f
sv/chcp_pkg.sv
sv/chcp_front.sv
sv/chcp_queue.sv
sv/chcp_lane.sv
sv/chcp_back.sv
sv/cubic_hermite_curve_points.sv
tb/sv/testbench.sv
